// ===== src/mma_pkg.sv =====
// Shared constants and register codes for the multichannel moving-average filter.
package mma_pkg;

	localparam int CHANNELS_DEF    = 8;
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CHANNEL_W   = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int WIN_FIELD_W = 7;
	localparam int ALPHA_W     = 16;
	localparam int CHAN_EN_W   = 8;
	localparam int FRAC_BITS   = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLED = 3'd0,
		CFG_MODE    = 3'd1,
		CFG_WINDOW  = 3'd2,
		CFG_ALPHA   = 3'd3,
		CFG_CHAN_EN = 3'd4
	} cfg_reg_t;

	localparam logic MODE_SMA = 1'b0;
	localparam logic MODE_EMA = 1'b1;

	localparam logic                 RST_ENABLED = 1'b1;
	localparam logic                 RST_MODE    = MODE_SMA;
	localparam int                   RST_WINDOW  = 8;
	localparam logic [ALPHA_W-1:0]   RST_ALPHA   = 16'd14564;
	localparam logic [CHAN_EN_W-1:0] RST_CHAN_EN = 8'hFF;

endpackage

// ===== src/multichannel_moving_average.sv =====
// Multichannel moving-average filter: simple window average and exponential average.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  config   | in        | cfg_write          | cfg_index, cfg_data
//  samples  | in        | in_valid/in_ready  | channel, sample
//  results  | out       | out_valid/out_ready| out_channel, filtered
//
// One word is processed at a time. A simple-mode word passes S_READ, S_ACC, the bit-serial
// restoring divider in S_DIV that divides the running sum by the fill count, and S_QUO.
// An exponential word passes S_EMA, the bit-serial alpha multiplier in S_MUL, S_EUPD and
// S_ROUND; a seeding word skips from S_EMA to S_ROUND, a bypassed word goes straight to S_OUT.
// The history memory is not cleared after reset: the per-channel fill count keeps unwritten
// entries from being read, so the block takes words right after reset.
// A result waits in the output register while the next word is accepted; a stalled output
// holds the block only when the following result is ready to leave.
module multichannel_moving_average #(
	parameter int CHANNELS    = mma_pkg::CHANNELS_DEF,
	parameter int WINDOW_MAX  = mma_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mma_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mma_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mma_pkg::CHANNEL_W-1:0]       channel,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mma_pkg::CHANNEL_W-1:0]       out_channel,
	output logic signed [SAMPLE_BITS-1:0]       filtered
);
	import mma_pkg::*;

	localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HW    = $clog2(WINDOW_MAX);
	localparam int WW    = $clog2(WINDOW_MAX + 1);
	localparam int WCW   = (WW > WIN_FIELD_W) ? WW : WIN_FIELD_W;
	localparam int DEPTH = CHANNELS * WINDOW_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUMW  = SAMPLE_BITS + HW;
	localparam int EW    = SAMPLE_BITS + FRAC_BITS;
	localparam int DW    = EW + 1;
	localparam int PW    = DW + ALPHA_W;
	localparam int CNTW  = $clog2(((SUMW > ALPHA_W) ? SUMW : ALPHA_W) + 1);
	localparam int HALF  = 1 << (FRAC_BITS - 1);
	localparam int RST_WIN_V = (WINDOW_MAX < RST_WINDOW) ? WINDOW_MAX : RST_WINDOW;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_READ  = 10'b0000000010,
		S_ACC   = 10'b0000000100,
		S_DIV   = 10'b0000001000,
		S_QUO   = 10'b0000010000,
		S_EMA   = 10'b0000100000,
		S_MUL   = 10'b0001000000,
		S_EUPD  = 10'b0010000000,
		S_ROUND = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic                 enabled_q;
	logic                 mode_q;
	logic [WW-1:0]        window_q;
	logic [ALPHA_W-1:0]   alpha_q;
	logic [CHAN_EN_W-1:0] chan_en_q;
	logic [WCW-1:0]       win_raw;
	logic [WW-1:0]        win_sat;
	logic                 window_clr;

	// Per-channel state.
	logic [HW-1:0]              head_q [CHANNELS];
	logic [WW-1:0]              fill_q [CHANNELS];
	logic signed [SUMW-1:0]     sum_q [CHANNELS];
	logic signed [EW-1:0]       ema_q [CHANNELS];
	logic                       started_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] hist_q [DEPTH];

	// Word being processed.
	logic [CHANNEL_W-1:0]          ch_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic [CHW-1:0]                ch_idx;

	// Serial divider and multiplier.
	logic [SUMW-1:0]        quo_q;
	logic [WW-1:0]          rem_q;
	logic [WW-1:0]          dvs_q;
	logic                   neg_q;
	logic signed [DW-1:0]   d_q;
	logic signed [PW-1:0]   acc_q;
	logic [ALPHA_W-1:0]     al_q;
	logic [CNTW-1:0]        cnt_q;

	// Output register.
	logic                          out_valid_q;
	logic [CHANNEL_W-1:0]          out_channel_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;

	logic                   in_fire;
	logic                   bypass_in;
	logic                   out_load;
	logic [HW-1:0]          h_cur;
	logic [HW-1:0]          head_nx;
	logic [WW-1:0]          fill_cur;
	logic [WW-1:0]          fill_nx;
	logic                   full;
	logic [AW-1:0]          mem_addr;
	logic signed [SUMW-1:0] sum_nx;
	logic [WW:0]            trial;
	logic [WW:0]            diff;
	logic                   ge;
	logic signed [EW-1:0]   ema_cur;
	logic signed [EW-1:0]   x_q16;
	logic signed [DW-1:0]   d_nx;
	logic signed [PW-1:0]   mul_term;
	logic signed [PW-1:0]   acc_rnd;
	logic signed [EW-1:0]   ema_nx;
	logic signed [EW-1:0]   e_rnd;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign bypass_in = !enabled_q || (int'(channel) >= CHANNELS) || !chan_en_q[channel];
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign filtered    = filtered_q;

	// Window writes saturate into the supported range.
	assign win_raw = WCW'(cfg_data[WIN_FIELD_W-1:0]);
	always_comb begin
		if (win_raw < WCW'(2)) begin
			win_sat = WW'(2);
		end else if (win_raw > WCW'(WINDOW_MAX)) begin
			win_sat = WW'(WINDOW_MAX);
		end else begin
			win_sat = WW'(win_raw);
		end
	end
	assign window_clr = cfg_write && (cfg_index == CFG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= RST_ENABLED;
			mode_q    <= RST_MODE;
			window_q  <= WW'(RST_WIN_V);
			alpha_q   <= RST_ALPHA;
			chan_en_q <= RST_CHAN_EN;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ENABLED: enabled_q <= cfg_data[0];
				CFG_MODE:    mode_q    <= cfg_data[0];
				CFG_WINDOW:  window_q  <= win_sat;
				CFG_ALPHA:   alpha_q   <= cfg_data[ALPHA_W-1:0];
				CFG_CHAN_EN: chan_en_q <= cfg_data[CHAN_EN_W-1:0];
				default: ;
			endcase
		end
	end

	// Simple-mode bookkeeping for the current channel.
	assign ch_idx   = CHW'(ch_q);
	assign h_cur    = (WW'(head_q[ch_idx]) >= window_q) ? '0 : head_q[ch_idx];
	assign head_nx  = ((WW'(h_cur) + WW'(1)) >= window_q) ? '0 : h_cur + HW'(1);
	assign fill_cur = fill_q[ch_idx];
	assign full     = (fill_cur >= window_q);
	assign fill_nx  = full ? fill_cur : fill_cur + WW'(1);
	assign mem_addr = AW'(ch_idx) * AW'(WINDOW_MAX) + AW'(h_cur);
	assign sum_nx   = sum_q[ch_idx] - (full ? SUMW'(old_q) : SUMW'(0)) + SUMW'(x_q);

	// One restoring-division step: shift in the next dividend bit, subtract if it fits.
	assign trial = {rem_q, quo_q[SUMW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// Exponential path, Q16 fixed point.
	assign ema_cur  = ema_q[ch_idx];
	assign x_q16    = {x_q, FRAC_BITS'(0)};
	assign d_nx     = DW'(x_q16) - DW'(ema_cur);
	assign mul_term = al_q[ALPHA_W-1] ? PW'(d_q) : PW'(0);
	assign acc_rnd  = acc_q + PW'(HALF);
	assign ema_nx   = ema_cur + EW'(acc_rnd >>> FRAC_BITS);
	assign e_rnd    = ema_cur + EW'(HALF);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (bypass_in) begin
							state_q <= S_OUT;
						end else if (mode_q == MODE_SMA) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_EMA;
						end
					end
				end
				S_READ: state_q <= S_ACC;
				S_ACC: begin
					cnt_q   <= CNTW'(SUMW);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						state_q <= S_QUO;
					end
				end
				S_QUO: state_q <= S_OUT;
				S_EMA: begin
					if (started_q[ch_idx]) begin
						cnt_q   <= CNTW'(ALPHA_W);
						state_q <= S_MUL;
					end else begin
						state_q <= S_ROUND;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						state_q <= S_EUPD;
					end
				end
				S_EUPD:  state_q <= S_ROUND;
				S_ROUND: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Per-channel control state; a window write restarts every simple average.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				head_q[i]    <= '0;
				fill_q[i]    <= '0;
				sum_q[i]     <= '0;
				started_q[i] <= 1'b0;
			end
		end else begin
			if (window_clr) begin
				for (int i = 0; i < CHANNELS; i++) begin
					head_q[i] <= '0;
					fill_q[i] <= '0;
					sum_q[i]  <= '0;
				end
			end else if (state_q == S_ACC) begin
				head_q[ch_idx] <= head_nx;
				fill_q[ch_idx] <= fill_nx;
				sum_q[ch_idx]  <= sum_nx;
			end
			if (state_q == S_EMA) begin
				started_q[ch_idx] <= 1'b1;
			end
		end
	end

	// Sample history: read in one state, overwritten with the new sample in the next.
	always_ff @(posedge clk) begin
		if (state_q == S_ACC) begin
			hist_q[mem_addr] <= x_q;
		end
		if (state_q == S_READ) begin
			old_q <= hist_q[mem_addr];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q  <= channel;
			x_q   <= sample;
			res_q <= sample;
		end
		case (state_q)
			S_ACC: begin
				neg_q <= sum_nx[SUMW-1];
				quo_q <= sum_nx[SUMW-1] ? SUMW'(-sum_nx) : SUMW'(sum_nx);
				rem_q <= '0;
				dvs_q <= fill_nx;
			end
			S_DIV: begin
				rem_q <= ge ? diff[WW-1:0] : trial[WW-1:0];
				quo_q <= {quo_q[SUMW-2:0], ge};
			end
			S_QUO: res_q <= SAMPLE_BITS'(neg_q ? (~quo_q + SUMW'(1)) : quo_q);
			S_EMA: begin
				if (started_q[ch_idx]) begin
					d_q   <= d_nx;
					acc_q <= '0;
					al_q  <= alpha_q;
				end else begin
					ema_q[ch_idx] <= x_q16;
				end
			end
			S_MUL: begin
				acc_q <= (acc_q <<< 1) + mul_term;
				al_q  <= al_q << 1;
			end
			S_EUPD:  ema_q[ch_idx] <= ema_nx;
			S_ROUND: res_q <= SAMPLE_BITS'(e_rnd >>> FRAC_BITS);
			default: ;
		endcase
		if (out_load) begin
			out_channel_q <= ch_q;
			filtered_q    <= res_q;
		end
	end

endmodule

// ===== src/mma_check.sv =====
// Port-level assertions for the moving-average filter, bound to its top level.
module mma_check #(
	parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [mma_pkg::CHANNEL_W-1:0]    out_channel,
	input logic signed [SAMPLE_BITS-1:0]    filtered
);
	import mma_pkg::*;

	// A result that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(out_channel))
		else $error("result word changed or dropped while stalled");

	// Only one word is in flight, so the input closes right after an accept.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while one is in flight");

	// A result is loaded only while the block is busy with its word.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

	// No new result can appear in the cycle that follows an accept.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared without processing time");

endmodule

bind multichannel_moving_average mma_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_mma_check (.*);
